// File: sv/length_prefixed_varint_codec_core_assert.svh
// Assertion macros shared by the codec modules.
`ifndef LENGTH_PREFIXED_VARINT_CODEC_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_VARINT_CODEC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons holds too.
`define LPVC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpvc assertion failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define LPVC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpvc assertion failed");
`else
`define LPVC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LPVC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/lpvc_pkg.sv
// Types and constants of the length-prefixed varint codec.
package lpvc_pkg;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   // Largest value that fits each encoded length.
   localparam logic [31:0] ENC_LIMIT_1 = 32'h0000_007f;
   localparam logic [31:0] ENC_LIMIT_2 = 32'h0000_1fff;
   localparam logic [31:0] ENC_LIMIT_3 = 32'h001f_ffff;
   localparam logic [31:0] ENC_LIMIT_4 = 32'h1fff_ffff;

   // Prefix codes in bits 7..5 of the first byte.
   localparam logic [2:0] PREFIX_2 = 3'd4;
   localparam logic [2:0] PREFIX_3 = 3'd5;
   localparam logic [2:0] PREFIX_4 = 3'd6;
   localparam logic [2:0] PREFIX_5 = 3'd7;
   localparam logic [2:0] PREFIX_BIAS = 3'd3;

   localparam int JOB_DATA_W = 40;

   // Job queue between front and back; depth is a power of two so the
   // pointers wrap on their own.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // One unit of work for the back end. Encoded bytes are left aligned in
   // data, first byte on top; a decoded value sits in the low 32 bits.
   typedef struct packed {
      logic                  kind;
      logic [2:0]            count;
      logic [JOB_DATA_W-1:0] data;
   } job_type;

endpackage

// File: sv/length_prefixed_varint_codec_core.sv
// Length-prefixed varint codec for 32-bit unsigned numbers.
//
// Input channel (req_*): push an item while req_full is low. An encode item
// (operation 0) takes req_value_in and yields one to five byte results; a
// decode item (operation 1) takes req_byte_in and yields a decoded number
// when the byte completes one, and otherwise nothing.
// Result channel (rsp_*): a result waits on the ports while rsp_empty is low
// and leaves on rsp_pop. rsp_last marks the final byte of an encoding and
// every decoded number.
// Flow: an accepted item passes the job queue and then the output register
// before its result can leave. The front end takes one item per cycle while
// req_full is low; the back end delivers one result per cycle while the
// receiver pops, and the four-job queue between them absorbs the difference.
// When the receiver stalls, the output register holds its item, the queue
// fills, and req_full rises once it is full.
// Reset clears the decoder (no number in progress), the queue and the valid
// flag of the output register.
module length_prefixed_varint_codec_core
   import lpvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic          req_operation,
   input  logic [31:0]   req_value_in,
   input  logic [7:0]    req_byte_in,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic          rsp_result_kind,
   output logic [7:0]    rsp_byte_out,
   output logic [31:0]   rsp_value_out,
   output logic          rsp_last
);

   logic    queue_full;
   logic    queue_empty;
   logic    job_push;
   logic    queue_pop;
   job_type job;
   job_type head_job;

   lpvc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_value_in  (req_value_in),
      .req_byte_in   (req_byte_in),
      .queue_full    (queue_full),
      .job_push      (job_push),
      .job           (job)
   );

   lpvc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (queue_pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   lpvc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head_job        (head_job),
      .queue_pop       (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_last        (rsp_last)
   );

endmodule

// File: sv/lpvc_front.sv
// Front end: accepts items, runs the decoder state and builds jobs.
module lpvc_front
   import lpvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic          req_operation,
   input  logic [31:0]   req_value_in,
   input  logic [7:0]    req_byte_in,
   input  logic          queue_full,
   output logic          job_push,
   output job_type       job
);

   logic [31:0] partial_ff;
   logic [31:0] partial_in;
   logic [2:0]  remain_ff;
   logic [2:0]  remain_in;
   logic        accept;
   logic [31:0] shifted;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;
   assign shifted  = {partial_ff[23:0], req_byte_in};

   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      job_push   = 1'b0;
      job        = '0;
      if (accept) begin
         if (req_operation == OP_ENCODE) begin
            job_push = 1'b1;
            job.kind = KIND_BYTE;
            if (req_value_in > ENC_LIMIT_4) begin
               job.count = 3'd5;
               job.data  = {PREFIX_5, 5'd0, req_value_in};
            end else if (req_value_in > ENC_LIMIT_3) begin
               job.count = 3'd4;
               job.data  = {PREFIX_4, req_value_in[28:0], 8'd0};
            end else if (req_value_in > ENC_LIMIT_2) begin
               job.count = 3'd3;
               job.data  = {PREFIX_3, req_value_in[20:0], 16'd0};
            end else if (req_value_in > ENC_LIMIT_1) begin
               job.count = 3'd2;
               job.data  = {PREFIX_2, req_value_in[12:0], 24'd0};
            end else begin
               job.count = 3'd1;
               job.data  = {req_value_in[7:0], 32'd0};
            end
         end else begin
            if (remain_ff == 3'd0) begin
               if (req_byte_in[7]) begin
                  partial_in = {27'd0, req_byte_in[4:0]};
                  remain_in  = req_byte_in[7:5] - PREFIX_BIAS;
               end else begin
                  job_push  = 1'b1;
                  job.kind  = KIND_VALUE;
                  job.count = 3'd1;
                  job.data  = JOB_DATA_W'(req_byte_in);
               end
            end else begin
               remain_in = remain_ff - 3'd1;
               if (remain_ff == 3'd1) begin
                  job_push   = 1'b1;
                  job.kind   = KIND_VALUE;
                  job.count  = 3'd1;
                  job.data   = JOB_DATA_W'(shifted);
                  partial_in = '0;
               end else begin
                  partial_in = shifted;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= '0;
      end else begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

// File: sv/lpvc_fifo.sv
// Short job queue that decouples the front end from the back end.
`include "length_prefixed_varint_codec_core_assert.svh"
module lpvc_fifo
   import lpvc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   job_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LPVC_ASSERT_IMP(a_no_push_when_full, clock, reset, push, !full)
   `LPVC_ASSERT_IMP(a_no_pop_when_empty, clock, reset, pop, !empty)
   `LPVC_ASSERT_IMP(a_count_bounded, clock, reset, 1'b1,
                    count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

// File: sv/lpvc_back.sv
// Back end: serializes jobs into result items through an output register.
`include "length_prefixed_varint_codec_core_assert.svh"
module lpvc_back
   import lpvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          queue_empty,
   input  job_type       head_job,
   output logic          queue_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic          rsp_result_kind,
   output logic [7:0]    rsp_byte_out,
   output logic [31:0]   rsp_value_out,
   output logic          rsp_last
);

   logic        out_valid_ff;
   logic        out_valid_in;
   logic        kind_ff;
   logic [7:0]  byte_ff;
   logic [31:0] value_ff;
   logic        last_ff;
   logic [2:0]  idx_ff;
   logic [2:0]  idx_in;
   logic        advance;
   logic        job_done;
   logic [7:0]  sel_byte;

   assign advance  = !queue_empty && (!out_valid_ff || rsp_pop);
   assign job_done = (idx_ff == head_job.count - 3'd1);
   assign sel_byte = head_job.data[(JOB_DATA_W - 1) - 8 * idx_ff -: 8];
   assign queue_pop = advance && job_done;

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         idx_in       = job_done ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff <= head_job.kind;
         if (head_job.kind == KIND_VALUE) begin
            byte_ff  <= '0;
            value_ff <= head_job.data[31:0];
            last_ff  <= 1'b1;
         end else begin
            byte_ff  <= sel_byte;
            value_ff <= '0;
            last_ff  <= job_done;
         end
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_byte_out    = byte_ff;
   assign rsp_value_out   = value_ff;
   assign rsp_last        = last_ff;

   // The byte index never runs past the length of the job at the head.
   `LPVC_ASSERT_IMP(a_idx_in_job, clock, reset, !queue_empty,
                    idx_ff < head_job.count)

endmodule
